>>> src/graph_coloring_conflict_counter_macros.svh
// ----------------------------------------------------------------------------
// Graph colouring conflict counter: assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef GRAPH_COLORING_CONFLICT_COUNTER_MACROS_SVH
`define GRAPH_COLORING_CONFLICT_COUNTER_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define GCC_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define GCC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define GCC_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define GCC_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

>>> src/gcc_pkg.sv
// ----------------------------------------------------------------------------
// Graph colouring conflict counter package
// Shared widths, request codes, register map and the result bundle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gcc_pkg;

   localparam int MAX_VERTICES_DEFAULT = 64;

   localparam int COLOR_W        = 9;
   localparam int COUNT_W        = 11;
   localparam int INDEX_W        = 6;
   localparam int NUM_VERTICES_W = 7;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   // request modes
   localparam logic [1:0] MODE_LOAD_ADJ   = 2'd0;
   localparam logic [1:0] MODE_LOAD_COLOR = 2'd1;
   localparam logic [1:0] MODE_EVALUATE   = 2'd2;

   // adjacency codes
   localparam logic [1:0] ADJ_NONE     = 2'd0;
   localparam logic [1:0] ADJ_EXCLUDED = 2'd2;

   // register map
   localparam int                   CSR_ADDR_W        = 2;
   localparam int                   CSR_DATA_W        = 32;
   localparam logic [CSR_ADDR_W-1:0] NUM_VERTICES_ADDR = 2'd0;
   localparam logic [NUM_VERTICES_W-1:0] NUM_VERTICES_RESET = 7'd64;

   typedef struct packed {
      logic               valid;
      logic [COUNT_W-1:0] count;
   } result_type;

endpackage

>>> src/graph_coloring_conflict_counter.sv
// ----------------------------------------------------------------------------
// Graph colouring conflict counter
// Loads an adjacency matrix one entry at a time and a colour per vertex, and
// on an evaluate request returns the number of conflicting pairs i<j: vertex i
// not excluded, both colours equal and an edge at (i,j). Load requests can
// follow back to back, also while a result waits to be taken. An evaluate
// request walks the matrix through one adjacency RAM (one bit per entry,
// the diagonal holding the exclusion flag) and one colour RAM, one read per
// cycle, and holds the request port until the count goes to the result
// register. No request is taken during a walk. Register num_vertices (byte
// address 0) sets n; values above MAX_VERTICES act as MAX_VERTICES and zero
// gives a count of zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "graph_coloring_conflict_counter_macros.svh"

module graph_coloring_conflict_counter #(
   parameter int MAX_VERTICES = gcc_pkg::MAX_VERTICES_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [1:0]                         req_mode,
   input  logic [gcc_pkg::INDEX_W-1:0]        req_row_index,
   input  logic [gcc_pkg::INDEX_W-1:0]        req_col_index,
   input  logic [1:0]                         req_adj_code,
   input  logic signed [gcc_pkg::COLOR_W-1:0] req_color,
   // result channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [gcc_pkg::COUNT_W-1:0]        rsp_conflict_count,
   // register port
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [gcc_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [gcc_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [gcc_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);

   localparam int IW        = $clog2(MAX_VERTICES);
   localparam int NW        = $clog2(MAX_VERTICES + 1);
   localparam int CMPW      = (NW > gcc_pkg::NUM_VERTICES_W) ? NW : gcc_pkg::NUM_VERTICES_W;
   // row index in the upper address bits, column in the lower ones
   localparam int ADJ_DEPTH = MAX_VERTICES * (2 ** IW);

   logic [gcc_pkg::NUM_VERTICES_W-1:0] num_vertices_ff;
   logic [NW-1:0]                      num_used;

   logic                        req_accept;
   logic                        row_ok;
   logic                        col_ok;
   logic                        adj_wr_en;
   logic                        adj_wr_data;
   logic [2*IW-1:0]             adj_wr_addr;
   logic                        col_wr_en;
   logic [IW-1:0]               col_wr_addr;
   logic                        start;
   logic                        busy;
   logic [2*IW-1:0]             adj_rd_addr;
   logic                        adj_rd_data;
   logic [IW-1:0]               col_rd_addr;
   logic [gcc_pkg::COLOR_W-1:0] col_rd_data;
   gcc_pkg::result_type         result;

   // ---- register port: one register, so every write lands in num_vertices
   always_ff @(posedge clock) begin
      if (reset) begin
         num_vertices_ff <= gcc_pkg::NUM_VERTICES_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         num_vertices_ff <= csr_pwdata[gcc_pkg::NUM_VERTICES_W-1:0];
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == gcc_pkg::NUM_VERTICES_ADDR) ?
                       gcc_pkg::CSR_DATA_W'(num_vertices_ff) : '0;

   // clamp the vertex count to what the RAMs hold
   assign num_used = (CMPW'(num_vertices_ff) > CMPW'(MAX_VERTICES)) ?
                     NW'(MAX_VERTICES) : NW'(num_vertices_ff);

   // ---- request decode: loads write straight into the RAMs
   assign req_accept = req_valid && !req_stall;
   assign req_stall  = busy;

   always_comb begin
      row_ok      = 32'(req_row_index) < MAX_VERTICES;
      col_ok      = 32'(req_col_index) < MAX_VERTICES;
      adj_wr_addr = {IW'(req_row_index), IW'(req_col_index)};
      col_wr_addr = IW'(req_row_index);
      // diagonal entry stores the exclusion flag, any other entry the edge bit
      adj_wr_data = (req_row_index == req_col_index) ?
                    (req_adj_code == gcc_pkg::ADJ_EXCLUDED) :
                    (req_adj_code != gcc_pkg::ADJ_NONE);
      adj_wr_en   = 1'b0;
      col_wr_en   = 1'b0;
      start       = 1'b0;
      unique case (req_mode)
         gcc_pkg::MODE_LOAD_ADJ: begin
            adj_wr_en = req_accept && row_ok && col_ok;
         end
         gcc_pkg::MODE_LOAD_COLOR: begin
            col_wr_en = req_accept && row_ok;
         end
         gcc_pkg::MODE_EVALUATE: begin
            start = req_accept;
         end
         default: begin
            // unused mode: drop the request
         end
      endcase
   end

   // ---- storage
   gcc_ram #(
      .WIDTH (1),
      .DEPTH (ADJ_DEPTH)
   ) u_adj_ram (
      .clock   (clock),
      .wr_en   (adj_wr_en),
      .wr_addr (adj_wr_addr),
      .wr_data (adj_wr_data),
      .rd_addr (adj_rd_addr),
      .rd_data (adj_rd_data)
   );

   gcc_ram #(
      .WIDTH (gcc_pkg::COLOR_W),
      .DEPTH (MAX_VERTICES)
   ) u_col_ram (
      .clock   (clock),
      .wr_en   (col_wr_en),
      .wr_addr (col_wr_addr),
      .wr_data ($unsigned(req_color)),
      .rd_addr (col_rd_addr),
      .rd_data (col_rd_data)
   );

   // ---- pair walk and result register
   gcc_walker #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_walker (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .num_used    (num_used),
      .busy        (busy),
      .adj_rd_addr (adj_rd_addr),
      .adj_rd_data (adj_rd_data),
      .col_rd_addr (col_rd_addr),
      .col_rd_data (col_rd_data),
      .rsp_stall   (rsp_stall),
      .result      (result)
   );

   assign rsp_valid          = result.valid;
   assign rsp_conflict_count = result.count;

   `GCC_ASSERT_NEXT(a_eval_holds_port, clock, reset, start, req_stall, "evaluate request did not hold the request port")

endmodule

>>> src/gcc_ram.sv
// ----------------------------------------------------------------------------
// Generic synchronous RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gcc_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/gcc_walker.sv
// ----------------------------------------------------------------------------
// Conflict walker
// Walks vertex pairs through the adjacency and colour RAMs, reads pipelined.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "graph_coloring_conflict_counter_macros.svh"

module gcc_walker #(
   parameter int  MAX_VERTICES = gcc_pkg::MAX_VERTICES_DEFAULT,
   localparam int IW           = $clog2(MAX_VERTICES),
   localparam int NW           = $clog2(MAX_VERTICES + 1)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [NW-1:0]               num_used,
   output logic                        busy,
   output logic [2*IW-1:0]             adj_rd_addr,
   input  logic                        adj_rd_data,
   output logic [IW-1:0]               col_rd_addr,
   input  logic [gcc_pkg::COLOR_W-1:0] col_rd_data,
   input  logic                        rsp_stall,
   output gcc_pkg::result_type         result
);

   typedef enum logic [2:0] {
      IDLE,
      HEAD,
      PAIR,
      DRAIN,
      FINISH
   } state_type;

   state_type                   state_ff;
   logic [NW-1:0]               n_ff;
   logic [NW-1:0]               i_ff;
   logic [NW-1:0]               j_ff;
   logic                        rd_valid_ff;
   logic                        rd_head_ff;
   logic                        excl_ff;
   logic [gcc_pkg::COLOR_W-1:0] ci_ff;
   logic [gcc_pkg::COUNT_W-1:0] count_ff;
   logic                        rsp_valid_ff;
   logic [gcc_pkg::COUNT_W-1:0] rsp_count_ff;

   logic [NW:0]                 i_next_in;
   logic [NW:0]                 j_next_in;
   logic                        i_more;
   logic                        j_more;
   logic                        issue;
   logic                        hit;
   logic [IW-1:0]               partner;

   always_comb begin
      i_next_in = {1'b0, i_ff} + 1'b1;
      j_next_in = {1'b0, j_ff} + 1'b1;
      i_more    = i_next_in < {1'b0, n_ff};
      j_more    = j_next_in < {1'b0, n_ff};
      issue     = (state_ff == HEAD) || (state_ff == PAIR);
      partner   = (state_ff == HEAD) ? i_ff[IW-1:0] : j_ff[IW-1:0];
      // the head read fetches the diagonal bit, which holds the exclusion flag
      adj_rd_addr = {i_ff[IW-1:0], partner};
      col_rd_addr = partner;
      hit = rd_valid_ff && !rd_head_ff && !excl_ff && adj_rd_data &&
            (col_rd_data == ci_ff) && (count_ff != gcc_pkg::COUNT_MAX);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= issue;
         rd_head_ff  <= (state_ff == HEAD);
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (rd_valid_ff && rd_head_ff) begin
            excl_ff <= adj_rd_data;
            ci_ff   <= col_rd_data;
         end
         if (hit) begin
            count_ff <= count_ff + 1'b1;
         end
         unique case (state_ff)
            IDLE: begin
               if (start) begin
                  count_ff <= '0;
                  n_ff     <= num_used;
                  i_ff     <= '0;
                  state_ff <= (num_used == '0) ? FINISH : HEAD;
               end
            end
            HEAD: begin
               j_ff     <= i_next_in[NW-1:0];
               state_ff <= i_more ? PAIR : DRAIN;
            end
            PAIR: begin
               if (j_more) begin
                  j_ff <= j_next_in[NW-1:0];
               end else if (i_more) begin
                  i_ff     <= i_next_in[NW-1:0];
                  state_ff <= HEAD;
               end else begin
                  state_ff <= DRAIN;
               end
            end
            DRAIN: begin
               state_ff <= FINISH;
            end
            FINISH: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_count_ff <= count_ff;
                  state_ff     <= IDLE;
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   assign busy         = (state_ff != IDLE);
   assign result.valid = rsp_valid_ff;
   assign result.count = rsp_count_ff;

   `GCC_ASSERT_IMPLY(a_pair_in_range, clock, reset, state_ff == PAIR, (j_ff > i_ff) && (j_ff < n_ff), "pair index outside the upper triangle")
   `GCC_ASSERT_IMPLY(a_finish_drained, clock, reset, state_ff == FINISH, !rd_valid_ff, "read still in flight when the count is taken")
   `GCC_ASSERT_NEXT(a_result_loaded, clock, reset, (state_ff == FINISH) && (!rsp_valid_ff || !rsp_stall), rsp_valid_ff && (state_ff == IDLE), "finished count not handed to the result register")

endmodule
